// File: hw/rtl/fsfe_pkg.sv
// Package for the shape fill engine: command codes, canvas constants and the
// command record passed from the front end to the drawing back end. No dependencies.
`default_nettype none
package fsfe_pkg;
  localparam int unsigned DefWidth  = 256;
  localparam int unsigned DefHeight = 128;
  localparam logic [31:0] OpaqueBlack = 32'h0000_00FF;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_SET   = 3'd1,
    OP_FILL  = 3'd2,
    OP_ROUND = 3'd3,
    OP_STROKE = 3'd4,
    OP_READ  = 3'd5,
    OP_NOP6  = 3'd6,
    OP_NOP7  = 3'd7
  } op_e;

  // One rectangle job for the back end. Coordinates are 18-bit signed, wide
  // enough for any sum of two 16-bit fields. Round jobs carry the clamped radius.
  typedef struct packed {
    op_e                op;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] w;
    logic signed [17:0] h;
    logic        [15:0] r;
    logic        [31:0] color;
    logic               last;
  } job_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_SWEEP,
    BE_READ,
    BE_READ_WAIT,
    BE_DONE
  } be_state_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_EMIT
  } fe_state_e;
endpackage
`default_nettype wire

// File: hw/rtl/fsfe_ram.sv
// Generic single-port RAM with registered read data. No dependencies.
`default_nettype none
module fsfe_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [DataW-1:0]         wdata_i,
  output logic      [DataW-1:0]         rdata_o
);
  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/fsfe_front.sv
// Front end: takes commands and breaks them into rectangle jobs (a stroke
// becomes four bands). Depends on fsfe_pkg.
`default_nettype none
module fsfe_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire logic [2:0]     operation_i,
  input  wire logic [15:0]    pos_x_i,
  input  wire logic [15:0]    pos_y_i,
  input  wire logic [15:0]    rect_width_i,
  input  wire logic [15:0]    rect_height_i,
  input  wire logic [15:0]    corner_radius_i,
  input  wire logic [15:0]    stroke_thickness_i,
  input  wire logic [31:0]    fill_color_i,
  output logic                job_valid_o,
  output fsfe_pkg::job_t      job_o,
  input  wire logic           job_ready_i
);
  import fsfe_pkg::*;

  fe_state_e state_q, state_d;
  logic [1:0] band_q, band_d;
  logic [2:0] op_q;
  logic signed [17:0] x_q, y_q, w_q, h_q, t_q;
  logic signed [17:0] rad_q;
  logic [31:0] color_q;
  logic signed [17:0] half_s, rcl_s;
  logic bad_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      band_q  <= '0;
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      op_q    <= operation_i;
      x_q     <= 18'(signed'(pos_x_i));
      y_q     <= 18'(signed'(pos_y_i));
      w_q     <= 18'(signed'(rect_width_i));
      h_q     <= 18'(signed'(rect_height_i));
      t_q     <= 18'(signed'(stroke_thickness_i));
      rad_q   <= 18'(signed'(corner_radius_i));
      color_q <= fill_color_i;
    end
  end

  assign full_o = (state_q != FE_IDLE);

  // Clamp radius to [0, min(w,h)/2]; sizes are positive when it matters.
  always_comb begin
    half_s = ((w_q < h_q) ? w_q : h_q) >>> 1;
    rcl_s  = (rad_q < half_s) ? rad_q : half_s;
    if (rcl_s < 0) begin
      rcl_s = '0;
    end
  end

  assign bad_s = (w_q <= 0) || (h_q <= 0) ||
                 ((op_e'(op_q) == OP_STROKE) && (t_q <= 0));

  always_comb begin
    state_d = state_q;
    band_d  = band_q;
    job_o.op    = op_e'(op_q);
    job_o.x     = x_q;
    job_o.y     = y_q;
    job_o.w     = w_q;
    job_o.h     = h_q;
    job_o.r     = rcl_s[15:0];
    job_o.color = color_q;
    job_o.last  = 1'b1;
    if ((op_e'(op_q) == OP_FILL || op_e'(op_q) == OP_ROUND || op_e'(op_q) == OP_STROKE)
        && bad_s) begin
      job_o.op = OP_NOP6;
    end
    if (op_e'(op_q) == OP_STROKE && !bad_s) begin
      job_o.op   = OP_FILL;
      job_o.last = (band_q == 2'd3);
      case (band_q)
        2'd0: job_o.h = t_q;
        2'd1: begin
          job_o.y = y_q + h_q - t_q;
          job_o.h = t_q;
        end
        2'd2: job_o.w = t_q;
        default: begin
          job_o.x = x_q + w_q - t_q;
          job_o.w = t_q;
        end
      endcase
    end
    job_valid_o = (state_q == FE_EMIT);
    case (state_q)
      FE_IDLE: begin
        band_d = '0;
        if (push_i) begin
          state_d = FE_EMIT;
        end
      end
      FE_EMIT: begin
        if (job_ready_i) begin
          band_d = band_q + 2'd1;
          if (job_o.last) begin
            state_d = FE_IDLE;
          end
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/fsfe_jobq.sv
// Two-entry job queue between front end and back end. Depends on fsfe_pkg.
`default_nettype none
module fsfe_jobq (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  fsfe_pkg::job_t in_job_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output fsfe_pkg::job_t out_job_o,
  input  wire logic      out_ready_i
);
  import fsfe_pkg::*;

  job_t       slot_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       do_push, do_pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_job_o   = slot_q[rd_q];
  assign do_push     = in_valid_i && in_ready_o;
  assign do_pop      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= in_job_i;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/fsfe_back.sv
// Back end: sweeps each clipped rectangle one pixel per cycle into the frame
// RAM, tests rounded corners, serves reads and posts results. Depends on
// fsfe_pkg and fsfe_ram.
`default_nettype none
module fsfe_back #(
  parameter int unsigned Width  = fsfe_pkg::DefWidth,
  parameter int unsigned Height = fsfe_pkg::DefHeight
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      job_valid_i,
  input  fsfe_pkg::job_t job_i,
  output logic           job_ready_o,
  output logic           res_valid_o,
  output logic [31:0]    res_color_o,
  output logic           res_off_o,
  input  wire logic      res_ready_i,
  output logic           clearing_o
);
  import fsfe_pkg::*;

  localparam int unsigned XW    = (Width > 1) ? $clog2(Width) : 1;
  localparam int unsigned YW    = (Height > 1) ? $clog2(Height) : 1;
  localparam int unsigned Depth = Width * Height;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  be_state_e state_q, state_d;
  job_t job_q;
  logic [XW-1:0] px_q, px_d, x0_q, x1_q;
  logic [YW-1:0] py_q, py_d, y1_q;
  logic [31:0] rcolor_q, rcolor_d;
  logic roff_q, roff_d, res_q, res_d;
  logic last_q, last_d;
  logic init_q;
  logic [AW-1:0] addr_s, waddr_s;
  logic we_s;
  logic [31:0] wdata_s, rdata_s;
  logic empty_s, hit_s, take_s;
  logic signed [17:0] cx0_s, cy0_s, cx1_s, cy1_s;
  logic signed [18:0] lx_s, ly_s, dx_s, dy_s;
  logic [35:0] d2_s;
  logic [31:0] r2_s;

  // Clip bounds of the incoming job.
  always_comb begin
    cx0_s = (job_i.x < 0) ? 18'sd0 : job_i.x;
    cy0_s = (job_i.y < 0) ? 18'sd0 : job_i.y;
    cx1_s = ((job_i.x + job_i.w) > $signed(18'(Width))) ? 18'(Width) : job_i.x + job_i.w;
    cy1_s = ((job_i.y + job_i.h) > $signed(18'(Height))) ? 18'(Height) :
            job_i.y + job_i.h;
    empty_s = (cx0_s >= cx1_s) || (cy0_s >= cy1_s);
  end

  // Corner test for rounded fills; the square of the distance is one
  // 19x19 multiply pair, compared to r squared.
  always_comb begin
    lx_s = 19'({{(18-XW){1'b0}}, px_q}) - 19'(job_q.x);
    ly_s = 19'({{(18-YW){1'b0}}, py_q}) - 19'(job_q.y);
    r2_s = job_q.r * job_q.r;
    dx_s = (lx_s < $signed({3'b0, job_q.r})) ? lx_s - ($signed({3'b0, job_q.r}) - 19'sd1)
                                             : lx_s - (19'(job_q.w) - $signed({3'b0, job_q.r}));
    dy_s = (ly_s < $signed({3'b0, job_q.r})) ? ly_s - ($signed({3'b0, job_q.r}) - 19'sd1)
                                             : ly_s - (19'(job_q.h) - $signed({3'b0, job_q.r}));
    d2_s = 36'(dx_s * dx_s) + 36'(dy_s * dy_s);
    if (job_q.op != OP_ROUND || job_q.r == '0) begin
      hit_s = 1'b1;
    end else if ((lx_s >= $signed({3'b0, job_q.r}) &&
                  lx_s < 19'(job_q.w) - $signed({3'b0, job_q.r})) ||
                 (ly_s >= $signed({3'b0, job_q.r}) &&
                  ly_s < 19'(job_q.h) - $signed({3'b0, job_q.r}))) begin
      hit_s = 1'b1;
    end else begin
      hit_s = (d2_s <= {4'b0, r2_s});
    end
  end

  assign waddr_s = AW'(py_q) * AW'(Width) + AW'(px_q);
  assign clearing_o = init_q;

  fsfe_ram #(.DataW(32), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_s),
    .addr_i  (addr_s),
    .wdata_i (wdata_s),
    .rdata_o (rdata_s)
  );

  assign take_s      = res_q && res_ready_i;
  assign res_valid_o = res_q;
  assign res_color_o = rcolor_q;
  assign res_off_o   = roff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_SWEEP;
      init_q  <= 1'b1;
      res_q   <= 1'b0;
      px_q    <= '0;
      py_q    <= '0;
      last_q  <= 1'b0;
      job_q.op    <= OP_CLEAR;
      job_q.color <= OpaqueBlack;
      x0_q <= '0;
      x1_q <= XW'(Width - 1);
      y1_q <= YW'(Height - 1);
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      px_q    <= px_d;
      py_q    <= py_d;
      last_q  <= last_d;
      if (state_q == BE_SWEEP && state_d != BE_SWEEP) begin
        init_q <= 1'b0;
      end
      if (job_valid_i && job_ready_o) begin
        job_q <= job_i;
        x0_q  <= (job_i.op == OP_CLEAR) ? '0 : XW'(cx0_s);
        x1_q  <= (job_i.op == OP_CLEAR) ? XW'(Width - 1) : XW'(cx1_s - 18'sd1);
        y1_q  <= (job_i.op == OP_CLEAR) ? YW'(Height - 1) : YW'(cy1_s - 18'sd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rcolor_q <= rcolor_d;
    roff_q   <= roff_d;
  end

  always_comb begin
    state_d  = state_q;
    px_d     = px_q;
    py_d     = py_q;
    last_d   = last_q;
    res_d    = res_q && !res_ready_i;
    rcolor_d = rcolor_q;
    roff_d   = roff_q;
    we_s     = 1'b0;
    addr_s   = waddr_s;
    wdata_s  = job_q.color;
    job_ready_o = 1'b0;
    case (state_q)
      BE_IDLE: begin
        job_ready_o = !res_q || res_ready_i;
        if (job_valid_i && job_ready_o) begin
          last_d   = job_i.last;
          rcolor_d = '0;
          roff_d   = 1'b0;
          px_d     = XW'(cx0_s);
          py_d     = YW'(cy0_s);
          case (job_i.op)
            OP_CLEAR: begin
              px_d = '0;
              py_d = '0;
              state_d = BE_SWEEP;
            end
            OP_SET, OP_FILL, OP_ROUND: begin
              if (job_i.op == OP_SET) begin
                px_d = XW'(job_i.x);
                py_d = YW'(job_i.y);
              end
              state_d = (job_i.op == OP_SET) ?
                        ((job_i.x >= 0 && job_i.y >= 0 &&
                          job_i.x < $signed(18'(Width)) && job_i.y < $signed(18'(Height)))
                         ? BE_SWEEP : BE_DONE)
                        : (empty_s ? BE_DONE : BE_SWEEP);
            end
            OP_READ: begin
              px_d = XW'(job_i.x);
              py_d = YW'(job_i.y);
              if (job_i.x >= 0 && job_i.y >= 0 &&
                  job_i.x < $signed(18'(Width)) && job_i.y < $signed(18'(Height))) begin
                state_d = BE_READ;
              end else begin
                rcolor_d = OpaqueBlack;
                roff_d   = 1'b1;
                state_d  = BE_DONE;
              end
            end
            default: state_d = BE_DONE;
          endcase
        end
      end
      BE_SWEEP: begin
        we_s = hit_s;
        if (job_q.op == OP_SET) begin
          state_d = BE_DONE;
        end else if (px_q == x1_q) begin
          px_d = x0_q;
          if (py_q == y1_q) begin
            state_d = init_q ? BE_IDLE : BE_DONE;
          end else begin
            py_d = py_q + YW'(1);
          end
        end else begin
          px_d = px_q + XW'(1);
        end
      end
      BE_READ: state_d = BE_READ_WAIT;
      BE_READ_WAIT: begin
        rcolor_d = rdata_s;
        state_d  = BE_DONE;
      end
      BE_DONE: begin
        if (!res_q || res_ready_i) begin
          res_d   = last_q;
          state_d = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/framebuffer_shape_fill_engine_top.sv
// Top level of the shape fill engine: front end, job queue and drawing back end.
// Depends on fsfe_pkg, fsfe_front, fsfe_jobq, fsfe_back and fsfe_ram.
`default_nettype none
// Each command returns one result. Fills write one pixel per cycle through the
// single frame RAM port, so the time a fill takes grows with the area of its
// clipped rectangle; a clear sweeps the whole frame and a stroke its four bands.
// After reset the back end sweeps the whole frame to opaque black before it
// takes a command; commands queue up at the front in the meantime.
module framebuffer_shape_fill_engine_top #(
  parameter int unsigned Width  = fsfe_pkg::DefWidth,
  parameter int unsigned Height = fsfe_pkg::DefHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  operation_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [15:0] rect_width_i,
  input  wire logic [15:0] rect_height_i,
  input  wire logic [15:0] corner_radius_i,
  input  wire logic [15:0] stroke_thickness_i,
  input  wire logic [31:0] fill_color_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      pixel_color_o,
  output logic             off_canvas_o
);
  import fsfe_pkg::*;

  logic fj_valid, fj_ready, bj_valid, bj_ready, res_valid, clearing;
  job_t fj, bj;

  fsfe_front u_front (
    .clk_i, .rst_ni,
    .push_i (push), .full_o (full),
    .operation_i, .pos_x_i, .pos_y_i, .rect_width_i, .rect_height_i,
    .corner_radius_i, .stroke_thickness_i, .fill_color_i,
    .job_valid_o (fj_valid), .job_o (fj), .job_ready_i (fj_ready)
  );

  fsfe_jobq u_jobq (
    .clk_i, .rst_ni,
    .in_valid_i (fj_valid), .in_job_i (fj), .in_ready_o (fj_ready),
    .out_valid_o (bj_valid), .out_job_o (bj), .out_ready_i (bj_ready)
  );

  fsfe_back #(.Width(Width), .Height(Height)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid), .job_i (bj), .job_ready_o (bj_ready),
    .res_valid_o (res_valid), .res_color_o (pixel_color_o), .res_off_o (off_canvas_o),
    .res_ready_i (pop), .clearing_o (clearing)
  );

  assign empty = !res_valid;

  a_off_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && off_canvas_o) |-> (pixel_color_o == OpaqueBlack))
    else $error("off-canvas result without opaque black");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_color_o)))
    else $error("waiting result changed");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (empty && !bj_ready))
    else $error("activity during reset clearing");
endmodule
`default_nettype wire
